[sv/wbps_pkg.sv]
// Package for the wildcard byte pattern scanner.
// Holds the sizes, the register index codes and the common types.
// No dependencies.
package wbps_pkg;

	// Pattern and offset sizes
	localparam int MAX_PATTERN  = 16;
	localparam int OFFSET_BITS  = 32;
	localparam int WIN_IDX_BITS = $clog2(MAX_PATTERN);
	localparam int LEN_BITS     = 5;
	localparam int FILL_BITS    = $clog2(MAX_PATTERN + 1);

	// Configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_CARE_MASK    = 3'd2,
		REG_PATTERN_LEN  = 3'd3,
		REG_WILD_EN      = 3'd4,
		REG_WILD_VALUE   = 3'd5,
		REG_OCC_SELECT   = 3'd6
	} cfg_reg_t;

	typedef logic [7:0]             byte_t;
	typedef logic [OFFSET_BITS-1:0] offset_t;

	// Reset values of the configuration registers
	localparam logic [MAX_PATTERN-1:0] CARE_MASK_RST = '1;
	localparam logic [LEN_BITS-1:0]    PAT_LEN_RST   = LEN_BITS'(1);

endpackage

[sv/wildcard_byte_pattern_scanner_core.sv]
// Top level of the wildcard byte pattern scanner: input stage, window,
// parallel masked compare, occurrence counter and result register.
// Depends on wbps_pkg.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------
//   in      | in        | in_valid / in_stall   | data_byte, last_byte
//   out     | out       | out_valid / out_stall | match_hit, match_offset,
//           |           |                       | region_done, not_found
//   cfg     | in        | cfg_we                | cfg_index, cfg_data
//
// One byte per cycle sustained while out_stall is low; an accepted beat is
// registered first in the input register and then in the result register,
// which raises out_valid.
// The window compare is one level of 16 byte muxes and comparators feeding an
// AND tree; the counter and offset update sit beside it in the same cycle.
// Reset clears the scan state and loads the register defaults.
// A stall on the output holds the result register and backs up into the
// input register; in_stall rises only when both are full.
module wildcard_byte_pattern_scanner_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          data_byte,
	input  logic                                last_byte,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                match_hit,
	output logic [31:0]                         match_offset,
	output logic                                region_done,
	output logic                                not_found,
	// configuration
	input  logic                                cfg_we,
	input  logic [wbps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [wbps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import wbps_pkg::*;

	// configuration registers
	logic [63:0]             pattern_low_q;
	logic [63:0]             pattern_high_q;
	logic [MAX_PATTERN-1:0]  care_mask_q;
	logic [LEN_BITS-1:0]     pattern_len_q;
	logic                    wild_en_q;
	byte_t                   wild_value_q;
	logic [7:0]              occ_select_q;

	// input stage
	logic                    valid_s1;
	byte_t                   data_s1;
	logic                    last_s1;

	// scan state
	byte_t                   window_q [MAX_PATTERN];
	logic [FILL_BITS-1:0]    fill_q;
	offset_t                 offset_q;
	logic [7:0]              count_q;
	logic                    found_q;

	// result register
	logic                    out_valid_q;
	logic                    hit_q;
	logic [31:0]             offset_out_q;
	logic                    done_q;
	logic                    not_found_q;

	// datapath
	logic                    advance;
	logic                    load_out;
	byte_t                   window_new [MAX_PATTERN];
	byte_t                   pat_byte [MAX_PATTERN];
	logic [LEN_BITS-1:0]     len_used;
	logic [FILL_BITS-1:0]    fill_new;
	logic [MAX_PATTERN-1:0]  pos_ok;
	logic [LEN_BITS-1:0]     win_pos [MAX_PATTERN];
	logic                    window_hit;
	logic                    counted;
	logic                    hit_now;
	offset_t                 start_off;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			care_mask_q    <= CARE_MASK_RST;
			pattern_len_q  <= PAT_LEN_RST;
			wild_en_q      <= 1'b0;
			wild_value_q   <= '0;
			occ_select_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:  pattern_low_q  <= cfg_data[63:0];
				REG_PATTERN_HIGH: pattern_high_q <= cfg_data[63:0];
				REG_CARE_MASK:    care_mask_q    <= cfg_data[MAX_PATTERN-1:0];
				REG_PATTERN_LEN:  pattern_len_q  <= cfg_data[LEN_BITS-1:0];
				REG_WILD_EN:      wild_en_q      <= cfg_data[0];
				REG_WILD_VALUE:   wild_value_q   <= cfg_data[7:0];
				REG_OCC_SELECT:   occ_select_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// handshake: result register frees up when empty or taken
	assign advance  = !out_valid_q || !out_stall;
	assign load_out = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// clamp length to 1..MAX_PATTERN
	always_comb begin
		if (pattern_len_q == '0) begin
			len_used = LEN_BITS'(1);
		end else if (pattern_len_q > LEN_BITS'(MAX_PATTERN)) begin
			len_used = LEN_BITS'(MAX_PATTERN);
		end else begin
			len_used = pattern_len_q;
		end
	end

	// shifted window, newest byte at entry 0
	always_comb begin
		window_new[0] = data_s1;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			window_new[k] = window_q[k-1];
		end
	end

	assign fill_new = (fill_q < FILL_BITS'(MAX_PATTERN)) ? fill_q + FILL_BITS'(1) : fill_q;

	// pattern byte j against the window byte that lines up with it
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			if (j < 8) begin
				pat_byte[j] = pattern_low_q[8*(j%8) +: 8];
			end else begin
				pat_byte[j] = pattern_high_q[8*(j%8) +: 8];
			end
			win_pos[j] = len_used - LEN_BITS'(1) - LEN_BITS'(j);
			pos_ok[j]  = (LEN_BITS'(j) >= len_used)
				|| !care_mask_q[j]
				|| (wild_en_q && (pat_byte[j] == wild_value_q))
				|| (pat_byte[j] == window_new[win_pos[j][WIN_IDX_BITS-1:0]]);
		end
	end

	assign window_hit = &pos_ok && (LEN_BITS'(fill_new) >= len_used) && !found_q;
	assign hit_now    = window_hit && (count_q == occ_select_q);
	assign counted    = window_hit && !hit_now && (count_q != 8'hFF);
	assign start_off  = offset_q - OFFSET_BITS'(len_used - LEN_BITS'(1));

	// scan state update, cleared after the last byte of a region
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				window_q[k] <= '0;
			end
			fill_q   <= '0;
			offset_q <= '0;
			count_q  <= '0;
			found_q  <= 1'b0;
		end else if (load_out) begin
			if (last_s1) begin
				for (int k = 0; k < MAX_PATTERN; k++) begin
					window_q[k] <= '0;
				end
				fill_q   <= '0;
				offset_q <= '0;
				count_q  <= '0;
				found_q  <= 1'b0;
			end else begin
				for (int k = 0; k < MAX_PATTERN; k++) begin
					window_q[k] <= window_new[k];
				end
				fill_q   <= fill_new;
				offset_q <= offset_q + OFFSET_BITS'(1);
				if (counted) begin
					count_q <= count_q + 8'd1;
				end
				if (hit_now) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			hit_q        <= hit_now;
			offset_out_q <= hit_now ? start_off[31:0] : 32'd0;
			done_q       <= last_s1;
			not_found_q  <= last_s1 && !found_q && !hit_now;
		end
	end

	assign out_valid    = out_valid_q;
	assign match_hit    = hit_q;
	assign match_offset = offset_out_q;
	assign region_done  = done_q;
	assign not_found    = not_found_q;

endmodule
